FILE: rtl/ccs_pkg.sv
// ----------------------------------------------------------------------------
// ccs_pkg
// Shared types and constants of the chunk container scanner.
// ----------------------------------------------------------------------------
package ccs_pkg;

    localparam int ID_W   = 31;
    localparam int WORD_W = 32;
    localparam int HDR_W  = 56;

    localparam logic [3:0] ST_OK         = 4'd0;
    localparam logic [3:0] ST_TOO_LARGE  = 4'd1;
    localparam logic [3:0] ST_TOO_SHORT  = 4'd2;
    localparam logic [3:0] ST_PARTIAL    = 4'd3;
    localparam logic [3:0] ST_COMPRESSED = 4'd4;
    localparam logic [3:0] ST_BAD_ID     = 4'd5;
    localparam logic [3:0] ST_DUPLICATE  = 4'd6;
    localparam logic [3:0] ST_PAST_END   = 4'd7;
    localparam logic [3:0] ST_MISSING    = 4'd8;

    localparam logic [2:0]        HDR_LAST_POS   = 3'd7;
    localparam logic [WORD_W-1:0] HDR_BYTES      = 32'd8;
    localparam logic [ID_W-1:0]   FIRST_ID       = 31'h1;
    localparam logic [ID_W-1:0]   FINAL_ID       = 31'h4;
    localparam logic [WORD_W-1:0] BYTE_COUNT_SAT = 32'hFFFF_FFFF;
    localparam logic [WORD_W-1:0] MAX_FILE_RST   = 32'hFFFF_FFFE;

    typedef struct packed {
        logic              is_final;
        logic [ID_W-1:0]   chunk_id;
        logic [WORD_W-1:0] payload_offset;
        logic [WORD_W-1:0] payload_size;
        logic [3:0]        status;
        logic              last_result;
    } ccs_result_t;

    typedef struct packed {
        logic [1:0]  count;
        ccs_result_t first;
        ccs_result_t second;
    } ccs_push_t;

endpackage

FILE: rtl/ccs_step.sv
// ----------------------------------------------------------------------------
// ccs_step
// Per-byte parse state and the results that one request produces.
// ----------------------------------------------------------------------------
module ccs_step
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       fire,
    input  logic [7:0]                 data_byte,
    input  logic                       last,
    input  logic [ccs_pkg::WORD_W-1:0] max_file_bytes,
    output ccs_pkg::ccs_push_t         push
);
    import ccs_pkg::*;

    logic [HDR_W-1:0]  hb_reg, hb_next;
    logic [2:0]        hp_reg, hp_next;
    logic [WORD_W-1:0] pl_reg, pl_next;
    logic [WORD_W-1:0] bc_reg, bc_next;
    logic [3:0]        seen_reg, seen_next;
    logic [3:0]        fe_reg, fe_next;
    logic [ID_W-1:0]   ec_reg, ec_next;
    logic [2:0]        act_reg, act_next;

    logic [WORD_W-1:0] bc_inc;
    logic [WORD_W-1:0] raw;
    logic [WORD_W-1:0] size;
    logic [ID_W-1:0]   id;
    logic [1:0]        idx;
    logic              desc_valid;
    ccs_result_t       desc;
    ccs_result_t       fin;
    logic [ID_W-1:0]   miss_id;
    logic              miss;

    always_comb
    begin
        bc_inc    = (bc_reg == BYTE_COUNT_SAT) ? bc_reg : bc_reg + 32'd1;
        hb_next   = hb_reg;
        hp_next   = hp_reg;
        pl_next   = pl_reg;
        seen_next = seen_reg;
        fe_next   = fe_reg;
        ec_next   = ec_reg;
        act_next  = act_reg;
        raw       = hb_reg[31:0];
        size      = {data_byte, hb_reg[55:32]};
        id        = raw[30:0];
        idx       = id[1:0] - 2'd1;
        desc_valid = 1'b0;

        if (fe_reg == ST_OK)
        begin
            if (pl_reg != '0)
            begin
                pl_next = pl_reg - 32'd1;
            end
            else if (hp_reg != HDR_LAST_POS)
            begin
                hb_next[{hp_reg, 3'b000} +: 8] = data_byte;
                hp_next = hp_reg + 3'd1;
            end
            else
            begin
                hb_next = '0;
                hp_next = '0;
                priority if (raw[31])
                begin
                    fe_next = ST_COMPRESSED;
                    ec_next = id;
                end
                else if (id < FIRST_ID || id > FINAL_ID)
                begin
                    fe_next = ST_BAD_ID;
                    ec_next = id;
                end
                else if (seen_reg[idx])
                begin
                    fe_next = ST_DUPLICATE;
                    ec_next = id;
                end
                else
                begin
                    seen_next[idx] = 1'b1;
                    act_next       = id[2:0];
                    pl_next        = size;
                    desc_valid     = 1'b1;
                end
            end
        end

        desc.is_final       = 1'b0;
        desc.chunk_id       = id;
        desc.payload_offset = bc_inc;
        desc.payload_size   = size;
        desc.status         = ST_OK;
        desc.last_result    = !last;

        miss    = 1'b0;
        miss_id = '0;
        for (int k = 3; k >= 0; k--)
        begin
            if (!seen_next[k])
            begin
                miss    = 1'b1;
                miss_id = ID_W'(k + 1);
            end
        end

        fin.is_final       = 1'b1;
        fin.chunk_id       = '0;
        fin.payload_offset = '0;
        fin.payload_size   = '0;
        fin.status         = ST_OK;
        fin.last_result    = 1'b1;
        priority if (bc_inc == BYTE_COUNT_SAT || bc_inc > max_file_bytes)
        begin
            fin.status = ST_TOO_LARGE;
        end
        else if (bc_inc < HDR_BYTES)
        begin
            fin.status = ST_TOO_SHORT;
        end
        else if (fe_next != ST_OK)
        begin
            fin.status   = fe_next;
            fin.chunk_id = ec_next;
        end
        else if (pl_next != '0)
        begin
            fin.status   = ST_PAST_END;
            fin.chunk_id = {28'd0, act_next};
        end
        else if (hp_next != '0)
        begin
            fin.status = ST_PARTIAL;
        end
        else if (miss)
        begin
            fin.status   = ST_MISSING;
            fin.chunk_id = miss_id;
        end
        else
        begin
            fin.status = ST_OK;
        end

        bc_next = bc_inc;
        if (last)
        begin
            hb_next   = '0;
            hp_next   = '0;
            pl_next   = '0;
            bc_next   = '0;
            seen_next = '0;
            fe_next   = ST_OK;
            ec_next   = '0;
            act_next  = '0;
        end

        push.first  = desc_valid ? desc : fin;
        push.second = fin;
        if (!fire)
            push.count = 2'd0;
        else
            push.count = 2'(desc_valid) + 2'(last);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hb_reg   <= '0;
            hp_reg   <= '0;
            pl_reg   <= '0;
            bc_reg   <= '0;
            seen_reg <= '0;
            fe_reg   <= ST_OK;
            ec_reg   <= '0;
            act_reg  <= '0;
        end
        else if (fire)
        begin
            hb_reg   <= hb_next;
            hp_reg   <= hp_next;
            pl_reg   <= pl_next;
            bc_reg   <= bc_next;
            seen_reg <= seen_next;
            fe_reg   <= fe_next;
            ec_reg   <= ec_next;
            act_reg  <= act_next;
        end
    end

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        fire && last |=> bc_reg == '0 && hp_reg == '0 && seen_reg == '0 && fe_reg == ST_OK)
        else $error("file state not cleared after last byte");

    a_payload_no_header: assert property (@(posedge clk) disable iff (!rst_n)
        pl_reg != '0 |-> hp_reg == '0 && fe_reg == ST_OK)
        else $error("payload skip overlaps header build");

    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        fe_reg != ST_OK && !(fire && last) |=> fe_reg == $past(fe_reg))
        else $error("chunk error changed within a file");

    a_error_no_desc: assert property (@(posedge clk) disable iff (!rst_n)
        fire && fe_reg != ST_OK |-> push.count == 2'(last))
        else $error("descriptor after chunk error");

endmodule

FILE: rtl/ccs_result_fifo.sv
// ----------------------------------------------------------------------------
// ccs_result_fifo
// Result queue: takes up to two results per cycle, hands out one.
// ----------------------------------------------------------------------------
module ccs_result_fifo
#(
    parameter int DEPTH = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  ccs_pkg::ccs_push_t   push,
    output logic                 room,
    output logic                 out_valid,
    input  logic                 out_ready,
    output ccs_pkg::ccs_result_t head
);
    import ccs_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ccs_result_t      mem_reg [DEPTH];
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [PTR_W-1:0] tail1;
    logic [PTR_W-1:0] tail2;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_comb
    begin
        pop        = out_valid && out_ready;
        tail1      = ptr_inc(tail_reg);
        tail2      = ptr_inc(tail1);
        head_next  = pop ? ptr_inc(head_reg) : head_reg;
        tail_next  = (push.count == 2'd2) ? tail2 :
                     (push.count == 2'd1) ? tail1 : tail_reg;
        count_next = count_reg + CNT_W'(push.count) - CNT_W'(pop);
    end

    assign out_valid = (count_reg != '0);
    assign room      = (count_reg <= CNT_W'(DEPTH - 2));
    assign head      = mem_reg[head_reg];

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem_reg[tail_reg] <= push.first;
        if (push.count == 2'd2)
            mem_reg[tail1] <= push.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("result queue overflow");

    a_push_with_room: assert property (@(posedge clk) disable iff (!rst_n)
        push.count != 2'd0 |-> count_reg <= CNT_W'(DEPTH - 2))
        else $error("push without room");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        pop && push.count == 2'd0 |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("queue count mismatch on pop");

endmodule

FILE: rtl/chunk_container_scanner_top.sv
// ----------------------------------------------------------------------------
// chunk_container_scanner_top
// Byte-stream chunk container scanner: chunk descriptors and file status.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+---------------------------------------
//  input    | in_valid / in_ready      | data_byte, last
//  output   | out_valid / out_ready    | is_final, chunk_id, payload_offset,
//           |                          | payload_size, status, last_result
//  config   | cfg_wr_en (no wait)      | cfg_wr_data -> max_file_bytes
//
// One request per cycle while in_ready is high; its results enter the result
// queue at the accept edge and leave it from the head, one result per cycle
// while out_ready is high. A request with a header end and last byte yields
// two results; in_ready holds while the queue has room for two results.
// Reset clears parse state and queue; max_file_bytes resets to 0xFFFFFFFE.
// ----------------------------------------------------------------------------
module chunk_container_scanner_top
#(
    parameter int FIFO_DEPTH = 4
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [7:0]                 data_byte,
    input  logic                       last,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       is_final,
    output logic [ccs_pkg::ID_W-1:0]   chunk_id,
    output logic [ccs_pkg::WORD_W-1:0] payload_offset,
    output logic [ccs_pkg::WORD_W-1:0] payload_size,
    output logic [3:0]                 status,
    output logic                       last_result,
    input  logic                       cfg_wr_en,
    input  logic [ccs_pkg::WORD_W-1:0] cfg_wr_data
);
    import ccs_pkg::*;

    logic [WORD_W-1:0] max_file_reg;
    logic              fire;
    ccs_push_t         push;
    ccs_result_t       head;

    assign fire = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_file_reg <= MAX_FILE_RST;
        else if (cfg_wr_en)
            max_file_reg <= cfg_wr_data;
    end

    ccs_step u_step
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .fire           (fire),
        .data_byte      (data_byte),
        .last           (last),
        .max_file_bytes (max_file_reg),
        .push           (push)
    );

    ccs_result_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign is_final       = head.is_final;
    assign chunk_id       = head.chunk_id;
    assign payload_offset = head.payload_offset;
    assign payload_size   = head.payload_size;
    assign status         = head.status;
    assign last_result    = head.last_result;

endmodule

FILE: sim/chunk_container_scanner_top_tb.sv
// ----------------------------------------------------------------------------
// chunk_container_scanner_top_tb
// Streams container files of chunk headers and payload bytes into the scanner
// under random source and sink gaps. A scoreboard tracks the parse state of
// each file, predicts every chunk descriptor and final status, and checks them
// field by field in order. Runs in phases over several max_file_bytes
// settings, including a long sink hold-off that fills the result queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module chunk_container_scanner_top_tb;

    import ccs_pkg::*;

    class ccs_scoreboard;

        logic [WORD_W-1:0] max_bytes;
        logic [HDR_W-1:0]  hdr_buf;
        logic [2:0]        hdr_pos;
        logic [WORD_W-1:0] payload_left;
        logic [WORD_W-1:0] byte_count;
        logic [3:0]        seen;
        logic [3:0]        first_err;
        logic [ID_W-1:0]   err_id;
        logic [2:0]        active_id;
        ccs_result_t       pending_results[$];
        int                errors;

        function new();
            max_bytes = MAX_FILE_RST;
            errors    = 0;
            clear_file();
        endfunction

        function void clear_file();
            hdr_buf      = '0;
            hdr_pos      = '0;
            payload_left = '0;
            byte_count   = '0;
            seen         = '0;
            first_err    = ST_OK;
            err_id       = '0;
            active_id    = '0;
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction

        function void note_byte(logic [7:0] b, logic is_last);
            logic [WORD_W-1:0] raw;
            logic [WORD_W-1:0] size;
            logic [ID_W-1:0]   id;
            ccs_result_t       desc;
            ccs_result_t       fin;
            bit                has_desc;
            has_desc = 1'b0;
            desc     = '0;
            fin      = '0;
            if (byte_count != BYTE_COUNT_SAT)
                byte_count++;
            if (first_err == ST_OK)
            begin
                if (payload_left != 0)
                    payload_left--;
                else if (hdr_pos != HDR_LAST_POS)
                begin
                    hdr_buf[8*hdr_pos +: 8] = b;
                    hdr_pos++;
                end
                else
                begin
                    raw     = hdr_buf[31:0];
                    size    = {b, hdr_buf[55:32]};
                    id      = raw[ID_W-1:0];
                    hdr_buf = '0;
                    hdr_pos = '0;
                    if (raw[WORD_W-1])
                    begin
                        first_err = ST_COMPRESSED;
                        err_id    = id;
                    end
                    else if (id < FIRST_ID || id > FINAL_ID)
                    begin
                        first_err = ST_BAD_ID;
                        err_id    = id;
                    end
                    else if (seen[id - FIRST_ID])
                    begin
                        first_err = ST_DUPLICATE;
                        err_id    = id;
                    end
                    else
                    begin
                        seen[id - FIRST_ID] = 1'b1;
                        active_id           = id[2:0];
                        payload_left        = size;
                        has_desc            = 1'b1;
                        desc.chunk_id       = id;
                        desc.payload_offset = byte_count;
                        desc.payload_size   = size;
                        desc.status         = ST_OK;
                    end
                end
            end
            if (is_last)
            begin
                fin.is_final = 1'b1;
                if (byte_count == BYTE_COUNT_SAT || byte_count > max_bytes)
                    fin.status = ST_TOO_LARGE;
                else if (byte_count < HDR_BYTES)
                    fin.status = ST_TOO_SHORT;
                else if (first_err != ST_OK)
                begin
                    fin.status   = first_err;
                    fin.chunk_id = err_id;
                end
                else if (payload_left != 0)
                begin
                    fin.status   = ST_PAST_END;
                    fin.chunk_id = {28'd0, active_id};
                end
                else if (hdr_pos != 0)
                    fin.status = ST_PARTIAL;
                else
                begin
                    // lowest missing id wins
                    for (int k = 3; k >= 0; k--)
                    begin
                        if (!seen[k])
                        begin
                            fin.status   = ST_MISSING;
                            fin.chunk_id = ID_W'(k + 1);
                        end
                    end
                end
                fin.last_result = 1'b1;
                clear_file();
            end
            if (has_desc)
            begin
                desc.last_result = !is_last;
                pending_results.insert(pending_results.size(), desc);
            end
            if (is_last)
                pending_results.insert(pending_results.size(), fin);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 100)
                $display("ERROR %0t: %s", $time, msg);
        endtask

        task check_result(ccs_result_t got);
            ccs_result_t want;
            if (pending_results.size() == 0)
            begin
                report($sformatf("unexpected result final=%0d id=%0d status=%0d",
                                 got.is_final, got.chunk_id, got.status));
                return;
            end
            want = pending_results.pop_front();
            if (got.is_final !== want.is_final)
                report($sformatf("is_final got %0d want %0d",
                                 got.is_final, want.is_final));
            if (got.chunk_id !== want.chunk_id)
                report($sformatf("chunk_id got %0h want %0h",
                                 got.chunk_id, want.chunk_id));
            if (got.payload_offset !== want.payload_offset)
                report($sformatf("payload_offset got %0h want %0h",
                                 got.payload_offset, want.payload_offset));
            if (got.payload_size !== want.payload_size)
                report($sformatf("payload_size got %0h want %0h",
                                 got.payload_size, want.payload_size));
            if (got.status !== want.status)
                report($sformatf("status got %0d want %0d", got.status, want.status));
            if (got.last_result !== want.last_result)
                report($sformatf("last_result got %0d want %0d",
                                 got.last_result, want.last_result));
        endtask

    endclass

    localparam logic [WORD_W-1:0] MARK_BIT    = 32'h8000_0000;
    localparam int                PHASE_BYTES = 125;
    localparam int                NUM_PHASES  = 5;
    localparam int                HOLD_CYCLES = 400;
    localparam int                STALL_LIMIT = 4000;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [7:0]        data_byte;
    logic              last;
    logic              out_valid;
    logic              out_ready;
    logic              is_final;
    logic [ID_W-1:0]   chunk_id;
    logic [WORD_W-1:0] payload_offset;
    logic [WORD_W-1:0] payload_size;
    logic [3:0]        status;
    logic              last_result;
    logic              cfg_wr_en;
    logic [WORD_W-1:0] cfg_wr_data;

    ccs_scoreboard sb = new();
    logic [7:0]    file_bytes[$];
    int            bytes_sent = 0;

    chunk_container_scanner_top u_top
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .last           (last),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .is_final       (is_final),
        .chunk_id       (chunk_id),
        .payload_offset (payload_offset),
        .payload_size   (payload_size),
        .status         (status),
        .last_result    (last_result),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int pick_gap(bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void add_word(logic [WORD_W-1:0] w);
        for (int i = 0; i < 4; i++)
            file_bytes.insert(file_bytes.size(), w[8*i +: 8]);
    endfunction

    function automatic void add_header(logic [WORD_W-1:0] id_word,
                                       logic [WORD_W-1:0] size);
        add_word(id_word);
        add_word(size);
    endfunction

    function automatic void add_payload(int n);
        for (int i = 0; i < n; i++)
            file_bytes.insert(file_bytes.size(), 8'($urandom_range(0, 255)));
    endfunction

    function automatic logic [WORD_W-1:0] bad_id_word();
        logic [WORD_W-1:0] w;
        case ($urandom_range(0, 3))
            0: w = 32'd0;
            1: w = 32'h7FFF_FFFF;
            2: w = $urandom_range(5, 255);
            default:
            begin
                w = $urandom & ~MARK_BIT;
                if (w >= FIRST_ID && w <= FINAL_ID)
                    w = w + 4;
            end
        endcase
        return w;
    endfunction

    function automatic void build_random_file();
        int                kind;
        int                n;
        int                j;
        int                tmp;
        int                sz;
        int                drop;
        int                order[4];
        logic [WORD_W-1:0] w;
        file_bytes.delete();
        kind = $urandom_range(0, 99);
        if (kind < 60)
        begin
            order = '{1, 2, 3, 4};
            for (int i = 3; i > 0; i--)
            begin
                j        = $urandom_range(0, i);
                tmp      = order[i];
                order[i] = order[j];
                order[j] = tmp;
            end
            n = ($urandom_range(0, 9) < 7) ? 4 : $urandom_range(1, 3);
            for (int i = 0; i < n; i++)
            begin
                sz = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40)
                                                 : $urandom_range(0, 8);
                if (i == n - 1 && $urandom_range(0, 3) == 0)
                    sz = 0;
                add_header(order[i], sz);
                add_payload(sz);
            end
            case ($urandom_range(0, 9))
                0:
                begin
                    drop = $urandom_range(1, (file_bytes.size() > 10) ? 10
                                                                     : file_bytes.size() - 1);
                    repeat (drop) void'(file_bytes.pop_back());
                end
                1:
                begin
                    add_header(order[0], $urandom_range(0, 4));
                    add_payload($urandom_range(0, 4));
                end
                2: add_payload($urandom_range(1, 7));
                3:
                begin
                    add_header($urandom_range(1, 4), $urandom | 32'h0001_0000);
                    add_payload($urandom_range(0, 5));
                end
                default: ;
            endcase
        end
        else if (kind < 75)
        begin
            tmp = $urandom_range(1, 4);
            if ($urandom_range(0, 1) == 1)
            begin
                sz = $urandom_range(0, 6);
                add_header(tmp, sz);
                add_payload(sz);
            end
            case ($urandom_range(0, 2))
                0: w = $urandom | MARK_BIT;
                1: w = bad_id_word();
                default:
                begin
                    add_header(tmp, 32'd0);
                    w = tmp;
                end
            endcase
            add_word(w);
            add_word($urandom);
            add_payload($urandom_range(0, 10));
        end
        else if (kind < 85)
            add_payload($urandom_range(1, 30));
        else
        begin
            add_header($urandom_range(1, 4), $urandom);
            add_payload($urandom_range(0, 12));
        end
    endfunction

    task automatic send_byte(logic [7:0] b, logic is_last, bit calm);
        int gap;
        gap = pick_gap(calm);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last      <= is_last;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_byte(b, is_last);
        bytes_sent++;
    endtask

    task automatic send_file();
        bit calm;
        calm = ($urandom_range(0, 3) == 0);
        foreach (file_bytes[i])
            send_byte(file_bytes[i], i == file_bytes.size() - 1, calm);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_max_bytes(logic [WORD_W-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en    <= 1'b0;
        sb.max_bytes  = v;
    endtask

    function automatic logic [WORD_W-1:0] max_bytes_for(int phase);
        logic [WORD_W-1:0] v;
        case (phase)
            1: v = 32'd8;
            2: v = $urandom_range(20, 80);
            3:
            begin
                v = $urandom;
                if (v < 8)
                    v = 32'd8;
                if (v == BYTE_COUNT_SAT)
                    v = MAX_FILE_RST;
            end
            default: v = MAX_FILE_RST;
        endcase
        return v;
    endfunction

    initial
    begin : sink
        int          stall_left;
        int          hold_left;
        int          calm_left;
        bit          calm;
        bit          held;
        ccs_result_t got;
        stall_left = 0;
        hold_left  = 0;
        calm_left  = 0;
        calm       = 1'b0;
        held       = 1'b0;
        out_ready  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                got.is_final       = is_final;
                got.chunk_id       = chunk_id;
                got.payload_offset = payload_offset;
                got.payload_size   = payload_size;
                got.status         = status;
                got.last_result    = last_result;
                sb.check_result(got);
            end
            if (calm_left == 0)
            begin
                calm      = ($urandom_range(0, 3) == 0);
                calm_left = 64;
            end
            else
                calm_left--;
            if (!held && bytes_sent >= 300)
            begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready  <= 1'b1;
                stall_left  = pick_gap(calm);
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("** chunk_container_scanner_top: FAILED **");
        $finish;
    end

    initial
    begin : stimulus
        int phase_start;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        data_byte   = '0;
        last        = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // one-byte file, header ending on the last byte, all-ones and all-zero headers
        file_bytes = '{8'hA5};
        send_file();
        file_bytes.delete();
        add_header(32'd1, 32'd0);
        send_file();
        file_bytes.delete();
        add_header(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_file();
        file_bytes.delete();
        add_header(32'd0, 32'd0);
        send_file();

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            if (phase > 0)
            begin
                drain();
                write_max_bytes(max_bytes_for(phase));
            end
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES)
            begin
                build_random_file();
                send_file();
            end
        end

        drain();
        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("** chunk_container_scanner_top: PASSED **");
        else
            $display("** chunk_container_scanner_top: FAILED **");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/ccs_pkg.sv
rtl/ccs_step.sv
rtl/ccs_result_fifo.sv
rtl/chunk_container_scanner_top.sv
sim/chunk_container_scanner_top_tb.sv
